/* src/bdq_pkg.sv */
// Package for the bounded deque: field widths, codes and controller/datapath structs.
package bdq_pkg;

    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DROP_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP_BACK  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_DROP_FRONT = 3'd3;
    localparam logic [2:0] OP_DROP_BACK  = 3'd4;

    typedef struct packed {
        logic [2:0]          op;
        logic                load_status;
        logic [STATUS_W-1:0] status;
        logic                list_clear;
        logic                list_read;
        logic                list_load;
    } bdq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic list_last;
    } bdq_stat_t;

endpackage

/* src/bdq_if.sv */
// Channel interfaces for the bounded deque: operation input and result output.
interface bdq_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [bdq_pkg::MODE_W-1:0] mode;
    logic signed [bdq_pkg::WORD_W-1:0] value_in;

    modport source (output valid, output mode, output value_in, input ready);
    modport sink   (input valid, input mode, input value_in, output ready);
endinterface

interface bdq_res_if;
    logic                         valid;
    logic                         ready;
    logic signed [bdq_pkg::WORD_W-1:0] value_out;
    logic [bdq_pkg::STATUS_W-1:0] status;
    logic                         last;

    modport source (output valid, output value_out, output status, output last, input ready);
    modport sink   (input valid, input value_out, input status, input last, output ready);
endinterface

/* src/bounded_deque_unit.sv */
// Top level of the bounded deque: controller, datapath and word store.
// Usage:
//   cmd carries one item per operation: mode (0 push front, 1 push back,
//   2 drop front, 3 drop back, 4 list) and value_in for pushes.
//   res returns value_out, status (0 ok, 1 empty, 2 full) and last.
//   A push or drop gives one result, which appears on res in the cycle after the item
//   is taken; cmd.ready stays high while res is ready, so these run one
//   item a cycle while res is not stalled.
//   A list on a non-empty queue streams every stored word front to back;
//   each word is first read from the ring store, then loaded into the
//   result register. The final word carries last. A list on an empty
//   queue gives one empty status. Modes 5 to 7 are taken and give nothing.
//   cmd.ready is low while a list streams and while a result waits.
//   Reset empties the queue; stored words are not cleared.
//   When res stalls, the result register holds and the block waits.
module bounded_deque_unit #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    bdq_cmd_if.sink        cmd,
    bdq_res_if.source      res
);

    bdq_pkg::bdq_cmd_t  ctl_cmd;
    bdq_pkg::bdq_stat_t dp_stat;

    bdq_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_mode  (cmd.mode),
        .in_ready (cmd.ready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    bdq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .value_in  (cmd.value_in),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .value_out (res.value_out),
        .status    (res.status),
        .last      (res.last)
    );

endmodule

/* src/bdq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bdq_datapath.sv */
// Datapath of the bounded deque: ring pointers, word store, list index, result register.
module bdq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bdq_pkg::bdq_cmd_t                 cmd,
    output bdq_pkg::bdq_stat_t                stat,
    input  logic signed [bdq_pkg::WORD_W-1:0] value_in,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [bdq_pkg::WORD_W-1:0] value_out,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic                              last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;

    logic                         ovalid_reg, ovalid_next;
    logic [bdq_pkg::WORD_W-1:0]   oval_reg, oval_next;
    logic [bdq_pkg::STATUS_W-1:0] ost_reg, ost_next;
    logic                         olast_reg, olast_next;

    logic [AW:0]   back_sum, read_sum, inc_sum;
    logic [AW-1:0] back_pos, read_pos, inc_pos, dec_pos;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [bdq_pkg::WORD_W-1:0] rd_data;
    logic          list_last;

    assign back_sum = {1'b0, front_reg} + (AW + 1)'(count_reg);
    assign read_sum = {1'b0, front_reg} + (AW + 1)'(idx_reg);
    assign inc_sum  = {1'b0, front_reg} + (AW + 1)'(1);

    assign back_pos = (back_sum >= (AW + 1)'(DEPTH)) ? AW'(back_sum - (AW + 1)'(DEPTH))
                                                     : back_sum[AW-1:0];
    assign read_pos = (read_sum >= (AW + 1)'(DEPTH)) ? AW'(read_sum - (AW + 1)'(DEPTH))
                                                     : read_sum[AW-1:0];
    assign inc_pos  = (inc_sum >= (AW + 1)'(DEPTH)) ? AW'(inc_sum - (AW + 1)'(DEPTH))
                                                    : inc_sum[AW-1:0];
    assign dec_pos  = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);

    assign list_last = ((idx_reg + CW'(1)) == count_reg);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = back_pos;
        unique case (cmd.op)
            bdq_pkg::OP_PUSH_FRONT:
            begin
                front_next = dec_pos;
                count_next = count_reg + CW'(1);
                wr_en      = 1'b1;
                wr_addr    = dec_pos;
            end
            bdq_pkg::OP_PUSH_BACK:
            begin
                count_next = count_reg + CW'(1);
                wr_en      = 1'b1;
                wr_addr    = back_pos;
            end
            bdq_pkg::OP_DROP_FRONT:
            begin
                front_next = inc_pos;
                count_next = count_reg - CW'(1);
            end
            bdq_pkg::OP_DROP_BACK:
            begin
                count_next = count_reg - CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.list_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.list_load)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        oval_next   = oval_reg;
        ost_next    = ost_reg;
        olast_next  = olast_reg;
        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        if (cmd.load_status)
        begin
            ovalid_next = 1'b1;
            oval_next   = '0;
            ost_next    = cmd.status;
            olast_next  = 1'b1;
        end
        else if (cmd.list_load)
        begin
            ovalid_next = 1'b1;
            oval_next   = rd_data;
            ost_next    = bdq_pkg::ST_OK;
            olast_next  = list_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oval_reg  <= oval_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_in),
        .rd_en   (cmd.list_read),
        .rd_addr (read_pos),
        .rd_data (rd_data)
    );

    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.out_free  = !ovalid_reg || out_ready;
    assign stat.list_last = list_last;

    assign out_valid = ovalid_reg;
    assign value_out = oval_reg;
    assign status    = ost_reg;
    assign last      = olast_reg;

endmodule

/* src/bdq_controller.sv */
// Controller of the bounded deque: decodes each item and sequences list reads.
module bdq_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [bdq_pkg::MODE_W-1:0] in_mode,
    output logic                       in_ready,
    input  bdq_pkg::bdq_stat_t         stat,
    output bdq_pkg::bdq_cmd_t          cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = bdq_pkg::OP_NONE;
        cmd.load_status = 1'b0;
        cmd.status      = bdq_pkg::ST_OK;
        cmd.list_clear  = 1'b0;
        cmd.list_read   = 1'b0;
        cmd.list_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_mode) inside
                        bdq_pkg::MODE_PUSH_FRONT, bdq_pkg::MODE_PUSH_BACK:
                        begin
                            cmd.load_status = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.op = (in_mode == bdq_pkg::MODE_PUSH_FRONT)
                                         ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
                            end
                        end
                        bdq_pkg::MODE_DROP_FRONT, bdq_pkg::MODE_DROP_BACK:
                        begin
                            cmd.load_status = 1'b1;
                            if (stat.empty)
                            begin
                                cmd.status = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.op = (in_mode == bdq_pkg::MODE_DROP_FRONT)
                                         ? bdq_pkg::OP_DROP_FRONT : bdq_pkg::OP_DROP_BACK;
                            end
                        end
                        bdq_pkg::MODE_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_status = 1'b1;
                                cmd.status      = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                cmd.list_clear = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                cmd.list_read = 1'b1;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.list_load = 1'b1;
                    state_next    = stat.list_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
